// ===== hw/rtl/arpi_pkg.sv =====
// Shared types and constants for the ARP packet inspector.
// Used by arpi_alu, arp_packet_inspector_core and the bench; no dependencies.
`timescale 1ns / 1ps

package arpi_pkg;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int CNT_W  = 32;
    localparam int KEY_W  = MAC_W + IP_W;
    localparam int APB_AW = 3;

    typedef logic [MAC_W-1:0] t_mac;
    typedef logic [IP_W-1:0]  t_ip;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [KEY_W-1:0] t_key;

    localparam t_mac       MAC_BCAST     = '1;
    localparam t_cnt       NOTICE_MARGIN = 32'd3;
    localparam logic       FUNC_LOAD     = 1'b1;
    localparam logic [1:0] OP_REQUEST    = 2'd1;
    localparam logic [1:0] OP_REPLY      = 2'd2;
    localparam logic       CFG_OWN_IP    = 1'b0;

    typedef struct packed {
        t_ip  src_ip;
        t_ip  dst_ip;
        t_cnt counter;
    } t_pair_entry;

    typedef struct packed {
        t_mac mac;
        t_ip  ip;
    } t_bind_entry;

    typedef struct packed {
        logic inconsistency_notice;
        logic sender_mac_mismatch;
        logic request_not_broadcast;
        logic binding_missing_error;
        logic reply_to_broadcast;
        logic bind_to_broadcast_error;
        logic pair_table_full;
        t_cnt pair_count;
        logic binding_dropped;
    } t_result;

    typedef struct packed {
        t_key cmp_a;
        t_key cmp_b;
        t_cnt add_a;
        t_cnt add_b;
        logic sub;
    } t_alu_req;

endpackage

// ===== hw/rtl/arpi_tbl.sv =====
// Simple dual-port table storage: one write and one registered read per cycle.
// Instanced once for the pair table and once for the binding table; no package dependency.
`timescale 1ns / 1ps

module arpi_tbl #(
    parameter int ENTRIES = 128,
    parameter int WIDTH   = 96,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/arpi_alu.sv =====
// Shared key comparator and 32-bit add/subtract unit used by every table scan.
// Depends on arpi_pkg for the request and key types.
`timescale 1ns / 1ps

module arpi_alu (
    input  arpi_pkg::t_alu_req i_req,
    output logic               o_eq,
    output arpi_pkg::t_cnt     o_sum
);
    import arpi_pkg::*;

    t_cnt add_b;

    assign add_b = i_req.sub ? ~i_req.add_b : i_req.add_b;
    assign o_sum = i_req.add_a + add_b + CNT_W'(i_req.sub);
    assign o_eq  = (i_req.cmp_a == i_req.cmp_b);

endmodule

// ===== hw/rtl/arp_packet_inspector_core.sv =====
// ARP packet inspector: pair counting, own-pair check and binding lookup.
// One item at a time; a scan reads one table entry per cycle via one port.
// Load and other opcodes go straight to DONE. A reply scans the bindings; a
// request scans the pairs, then the own pair unless the sender is own_ip.
// Reset (synchronous, active low) clears own_ip, both fill counts and control.
// Depends on arpi_pkg, arpi_tbl and arpi_alu.
`timescale 1ns / 1ps

module arp_packet_inspector_core #(
    parameter int PAIR_ENTRIES    = 128,
    parameter int BINDING_ENTRIES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [arpi_pkg::APB_AW-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [1:0]                        i_arp_op,
    input  arpi_pkg::t_mac                    i_eth_src_mac,
    input  arpi_pkg::t_mac                    i_eth_dst_mac,
    input  arpi_pkg::t_mac                    i_arp_src_mac,
    input  arpi_pkg::t_mac                    i_arp_dst_mac,
    input  arpi_pkg::t_ip                     i_arp_src_ip,
    input  arpi_pkg::t_ip                     i_arp_dst_ip,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_inconsistency_notice,
    output logic                              o_sender_mac_mismatch,
    output logic                              o_request_not_broadcast,
    output logic                              o_binding_missing_error,
    output logic                              o_reply_to_broadcast,
    output logic                              o_bind_to_broadcast_error,
    output logic                              o_pair_table_full,
    output arpi_pkg::t_cnt                    o_pair_count,
    output logic                              o_binding_dropped
);
    import arpi_pkg::*;

    localparam int PW  = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int BW  = (BINDING_ENTRIES > 1) ? $clog2(BINDING_ENTRIES) : 1;
    localparam int PCW = $clog2(PAIR_ENTRIES + 1);
    localparam int BCW = $clog2(BINDING_ENTRIES + 1);
    localparam int SW  = (PCW > BCW) ? PCW : BCW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN1,
        S_PSCAN2,
        S_DIFF,
        S_BSCAN,
        S_DONE
    } t_state;

    t_state       r_state;
    t_ip          r_own_ip;
    logic [PCW-1:0] r_pfill;
    logic [BCW-1:0] r_bfill;
    logic [SW-1:0]  r_scan;
    logic [SW-1:0]  r_rd_idx;
    logic           r_rd_vld;
    t_mac         r_arp_src_mac;
    t_ip          r_sip;
    t_ip          r_dip;
    t_cnt         r_c1;
    t_cnt         r_c2;
    t_result      r_res;
    t_result      r_out;
    logic         r_out_vld;

    t_pair_entry  p_rd;
    t_bind_entry  b_rd;
    t_pair_entry  p_wr_data;
    t_bind_entry  b_wr_data;
    logic         p_rd_en;
    logic         p_wr_en;
    logic [PW-1:0] p_wr_addr;
    logic         b_rd_en;
    logic         b_wr_en;
    t_alu_req     alu_req;
    logic         alu_eq;
    t_cnt         alu_sum;
    logic         hit;
    logic         more;
    logic         in_fire;
    logic         pair_room;
    logic         bind_room;
    t_result      in_res;
    logic [SW-1:0] scan_lim;

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == CFG_OWN_IP) ? r_own_ip : 32'd0;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign pair_room  = (r_pfill < PCW'(PAIR_ENTRIES));
    assign bind_room  = (r_bfill < BCW'(BINDING_ENTRIES));

    assign scan_lim = (r_state == S_BSCAN) ? SW'(r_bfill) : SW'(r_pfill);
    assign more     = (r_scan < scan_lim);
    assign hit      = r_rd_vld && alu_eq;

    always_comb begin
        alu_req.cmp_b = (r_state == S_BSCAN) ? t_key'({b_rd.mac, b_rd.ip})
                                             : t_key'({p_rd.src_ip, p_rd.dst_ip});
        case (r_state)
            S_BSCAN:  alu_req.cmp_a = t_key'({r_arp_src_mac, r_sip});
            S_PSCAN2: alu_req.cmp_a = t_key'({r_own_ip, r_dip});
            default:  alu_req.cmp_a = t_key'({r_sip, r_dip});
        endcase
        if (r_state == S_DIFF) begin
            alu_req.add_a = r_c1;
            alu_req.add_b = r_c2;
            alu_req.sub   = 1'b1;
        end else begin
            alu_req.add_a = p_rd.counter;
            alu_req.add_b = CNT_W'(1);
            alu_req.sub   = 1'b0;
        end
    end

    arpi_alu u_alu (
        .i_req (alu_req),
        .o_eq  (alu_eq),
        .o_sum (alu_sum)
    );

    always_comb begin
        p_rd_en   = ((r_state == S_PSCAN1) || (r_state == S_PSCAN2)) && !hit && more;
        p_wr_en   = 1'b0;
        p_wr_addr = r_rd_idx[PW-1:0];
        p_wr_data = '{src_ip: p_rd.src_ip, dst_ip: p_rd.dst_ip, counter: alu_sum};
        if ((r_state == S_PSCAN1) || (r_state == S_PSCAN2)) begin
            if (hit) begin
                p_wr_en = 1'b1;
            end else if (!more && (r_state == S_PSCAN1) && pair_room) begin
                p_wr_en   = 1'b1;
                p_wr_addr = r_pfill[PW-1:0];
                p_wr_data = '{src_ip: r_sip, dst_ip: r_dip, counter: CNT_W'(1)};
            end
        end
        b_rd_en   = (r_state == S_BSCAN) && !hit && more;
        b_wr_en   = in_fire && (i_func == FUNC_LOAD) && bind_room;
        b_wr_data = '{mac: i_arp_src_mac, ip: i_arp_src_ip};
    end

    arpi_tbl #(
        .ENTRIES (PAIR_ENTRIES),
        .WIDTH   ($bits(t_pair_entry)),
        .AW      (PW)
    ) u_pair_tbl (
        .i_clk     (i_clk),
        .i_rd_en   (p_rd_en),
        .i_rd_addr (r_scan[PW-1:0]),
        .o_rd_data (p_rd),
        .i_wr_en   (p_wr_en),
        .i_wr_addr (p_wr_addr),
        .i_wr_data (p_wr_data)
    );

    arpi_tbl #(
        .ENTRIES (BINDING_ENTRIES),
        .WIDTH   ($bits(t_bind_entry)),
        .AW      (BW)
    ) u_bind_tbl (
        .i_clk     (i_clk),
        .i_rd_en   (b_rd_en),
        .i_rd_addr (r_scan[BW-1:0]),
        .o_rd_data (b_rd),
        .i_wr_en   (b_wr_en),
        .i_wr_addr (r_bfill[BW-1:0]),
        .i_wr_data (b_wr_data)
    );

    always_comb begin
        in_res = '0;
        if (i_func == FUNC_LOAD) begin
            in_res.binding_dropped = !bind_room;
        end else if (i_arp_op == OP_REQUEST) begin
            in_res.sender_mac_mismatch   = (i_arp_src_mac != i_eth_src_mac);
            in_res.request_not_broadcast = (i_eth_dst_mac != MAC_BCAST);
        end else if (i_arp_op == OP_REPLY) begin
            in_res.sender_mac_mismatch     = (i_arp_src_mac != i_eth_src_mac);
            in_res.reply_to_broadcast      = (i_eth_dst_mac == MAC_BCAST);
            in_res.bind_to_broadcast_error = (i_arp_dst_mac == MAC_BCAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_own_ip  <= '0;
            r_pfill   <= '0;
            r_bfill   <= '0;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == CFG_OWN_IP)) begin
                r_own_ip <= pwdata;
            end
            if (r_out_vld && i_out_ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_arp_src_mac <= i_arp_src_mac;
                        r_sip         <= i_arp_src_ip;
                        r_dip         <= i_arp_dst_ip;
                        r_res         <= in_res;
                        r_scan        <= '0;
                        r_rd_vld      <= 1'b0;
                        if (i_func == FUNC_LOAD) begin
                            if (bind_room) begin
                                r_bfill <= r_bfill + BCW'(1);
                            end
                            r_state <= S_DONE;
                        end else if (i_arp_op == OP_REQUEST) begin
                            r_state <= S_PSCAN1;
                        end else if (i_arp_op == OP_REPLY) begin
                            r_state <= S_BSCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PSCAN1: begin
                    if (hit || !more) begin
                        if (hit) begin
                            r_c1             <= alu_sum;
                            r_res.pair_count <= alu_sum;
                        end else if (pair_room) begin
                            r_pfill          <= r_pfill + PCW'(1);
                            r_c1             <= CNT_W'(1);
                            r_res.pair_count <= CNT_W'(1);
                        end else begin
                            r_c1                  <= '0;
                            r_res.pair_table_full <= 1'b1;
                        end
                        r_scan   <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= (r_sip != r_own_ip) ? S_PSCAN2 : S_DONE;
                    end else begin
                        r_rd_idx <= r_scan;
                        r_rd_vld <= 1'b1;
                        r_scan   <= r_scan + SW'(1);
                    end
                end
                S_PSCAN2: begin
                    if (hit || !more) begin
                        r_c2     <= hit ? alu_sum : CNT_W'(1);
                        r_rd_vld <= 1'b0;
                        r_state  <= S_DIFF;
                    end else begin
                        r_rd_idx <= r_scan;
                        r_rd_vld <= 1'b1;
                        r_scan   <= r_scan + SW'(1);
                    end
                end
                S_DIFF: begin
                    r_res.inconsistency_notice <= (alu_sum > NOTICE_MARGIN);
                    r_state                    <= S_DONE;
                end
                S_BSCAN: begin
                    if (hit || !more) begin
                        r_res.binding_missing_error <= !hit;
                        r_rd_vld                    <= 1'b0;
                        r_state                     <= S_DONE;
                    end else begin
                        r_rd_idx <= r_scan;
                        r_rd_vld <= 1'b1;
                        r_scan   <= r_scan + SW'(1);
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || i_out_ready) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid               = r_out_vld;
    assign o_inconsistency_notice    = r_out.inconsistency_notice;
    assign o_sender_mac_mismatch     = r_out.sender_mac_mismatch;
    assign o_request_not_broadcast   = r_out.request_not_broadcast;
    assign o_binding_missing_error   = r_out.binding_missing_error;
    assign o_reply_to_broadcast      = r_out.reply_to_broadcast;
    assign o_bind_to_broadcast_error = r_out.bind_to_broadcast_error;
    assign o_pair_table_full         = r_out.pair_table_full;
    assign o_pair_count              = r_out.pair_count;
    assign o_binding_dropped         = r_out.binding_dropped;

    a_pfill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pfill <= PCW'(PAIR_ENTRIES))
        else $error("pair fill count beyond table depth");

    a_bfill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bfill == $past(r_bfill)) || (r_bfill == $past(r_bfill) + BCW'(1)))
        else $error("binding fill count jumped");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted beat did not leave idle");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_table_full) |-> (o_pair_count == '0))
        else $error("full pair table with nonzero count");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for arp_packet_inspector_core: directed and random ARP beats
// checked against an inline model of the pair counter and binding tables.
// Depends on arpi_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import arpi_pkg::*;

    localparam int PAIR_DEPTH  = 128;
    localparam int BIND_DEPTH  = 64;
    localparam int POOL        = 6;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic       FUNC_INSPECT = 1'b0;
    localparam logic [1:0] OP_OTHER     = 2'd0;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_OWN_IP = APB_AW'(4 * CFG_OWN_IP);
    localparam logic [APB_AW-1:0] ADDR_SPARE  = APB_AW'(4 * (CFG_OWN_IP + 1));

    typedef struct packed {
        logic       func;
        logic [1:0] op;
        t_mac       eth_src;
        t_mac       eth_dst;
        t_mac       arp_smac;
        t_mac       arp_dmac;
        t_ip        sip;
        t_ip        dip;
    } t_arp_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_func;
    logic [1:0]        i_arp_op;
    t_mac              i_eth_src_mac;
    t_mac              i_eth_dst_mac;
    t_mac              i_arp_src_mac;
    t_mac              i_arp_dst_mac;
    t_ip               i_arp_src_ip;
    t_ip               i_arp_dst_ip;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_inconsistency_notice;
    logic              o_sender_mac_mismatch;
    logic              o_request_not_broadcast;
    logic              o_binding_missing_error;
    logic              o_reply_to_broadcast;
    logic              o_bind_to_broadcast_error;
    logic              o_pair_table_full;
    t_cnt              o_pair_count;
    logic              o_binding_dropped;

    arp_packet_inspector_core #(
        .PAIR_ENTRIES   (PAIR_DEPTH),
        .BINDING_ENTRIES(BIND_DEPTH)
    ) u_top (.*);

    // inspector model state
    t_ip  own_ip_q;
    t_ip  pair_src [PAIR_DEPTH];
    t_ip  pair_dst [PAIR_DEPTH];
    t_cnt pair_cnt [PAIR_DEPTH];
    int   pair_used;
    t_mac bind_mac [BIND_DEPTH];
    t_ip  bind_ip  [BIND_DEPTH];
    int   bind_used;

    t_ip  ip_pool  [POOL];
    t_mac mac_pool [POOL];

    t_arp_item arp_backlog[$];
    t_result   verdict_q[$];
    t_arp_item on_wire;
    t_result   want;

    int   beats_queued;
    int   beats_out;
    int   errors;
    int   gap_left;
    int   stall_left;
    int   hold_left;
    int   cycle_cnt;
    logic hold_kick;
    logic calm;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_mac rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic int find_pair(input t_ip a, input t_ip b);
        for (int k = 0; k < pair_used; k++) begin
            if (pair_src[k] == a && pair_dst[k] == b) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic t_result inspect_arp(input t_arp_item it);
        t_result r;
        int      hit;
        int      own_hit;
        t_cnt    c1;
        t_cnt    c2;
        logic    bound;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            if (bind_used < BIND_DEPTH) begin
                bind_mac[bind_used] = it.arp_smac;
                bind_ip[bind_used]  = it.sip;
                bind_used++;
            end else begin
                r.binding_dropped = 1'b1;
            end
        end else if (it.op == OP_REQUEST) begin
            hit = find_pair(it.sip, it.dip);
            if (hit >= 0) begin
                pair_cnt[hit] = pair_cnt[hit] + 32'd1;
                c1 = pair_cnt[hit];
            end else if (pair_used < PAIR_DEPTH) begin
                pair_src[pair_used] = it.sip;
                pair_dst[pair_used] = it.dip;
                pair_cnt[pair_used] = 32'd1;
                pair_used++;
                c1 = 32'd1;
            end else begin
                c1 = '0;
                r.pair_table_full = 1'b1;
            end
            r.pair_count = c1;
            if (it.sip != own_ip_q) begin
                c2 = 32'd1;
                own_hit = find_pair(own_ip_q, it.dip);
                if (own_hit >= 0) begin
                    pair_cnt[own_hit] = pair_cnt[own_hit] + 32'd1;
                    c2 = pair_cnt[own_hit];
                end
                r.inconsistency_notice = t_cnt'(c1 - c2) > NOTICE_MARGIN;
            end
            r.sender_mac_mismatch   = it.arp_smac != it.eth_src;
            r.request_not_broadcast = it.eth_dst != MAC_BCAST;
        end else if (it.op == OP_REPLY) begin
            bound = 1'b0;
            for (int k = 0; k < bind_used; k++) begin
                if (bind_mac[k] == it.arp_smac && bind_ip[k] == it.sip) begin
                    bound = 1'b1;
                end
            end
            r.binding_missing_error   = !bound;
            r.reply_to_broadcast      = it.eth_dst == MAC_BCAST;
            r.sender_mac_mismatch     = it.arp_smac != it.eth_src;
            r.bind_to_broadcast_error = it.arp_dmac == MAC_BCAST;
        end
        return r;
    endfunction

    function automatic t_arp_item mk(input logic func, input logic [1:0] op,
                                     input t_mac esrc, input t_mac edst,
                                     input t_mac asmac, input t_mac admac,
                                     input t_ip sip, input t_ip dip);
        t_arp_item it;
        it.func     = func;
        it.op       = op;
        it.eth_src  = esrc;
        it.eth_dst  = edst;
        it.arp_smac = asmac;
        it.arp_dmac = admac;
        it.sip      = sip;
        it.dip      = dip;
        return it;
    endfunction

    function automatic t_arp_item random_item();
        t_arp_item it;
        int        pick;
        int        k;
        it = mk(FUNC_INSPECT, 2'($urandom_range(0, 3)), rand_mac(), rand_mac(),
                rand_mac(), rand_mac(), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL - 1);
        if (pick < 12) begin
            it.func = FUNC_LOAD;
            if ($urandom_range(0, 3) != 0) begin
                it.arp_smac = mac_pool[k];
                it.sip      = ip_pool[k];
            end
        end else if (pick < 20) begin
            it.op = ($urandom_range(0, 1) == 0) ? OP_OTHER : OP_RESERVED;
        end else if (pick < 65) begin
            it.op = OP_REQUEST;
            if ($urandom_range(0, 9) != 0) begin
                it.sip = ($urandom_range(0, 6) == 0) ? own_ip_q : ip_pool[k];
                it.dip = ip_pool[$urandom_range(0, 3)];
            end
            if ($urandom_range(0, 9) < 7) it.eth_dst = MAC_BCAST;
            if ($urandom_range(0, 9) < 7) it.arp_smac = it.eth_src;
        end else begin
            it.op = OP_REPLY;
            if ($urandom_range(0, 9) < 6) begin
                it.arp_smac = mac_pool[k];
                it.sip      = ip_pool[k];
            end
            if ($urandom_range(0, 9) < 3) it.eth_dst = MAC_BCAST;
            if ($urandom_range(0, 9) < 3) it.arp_dmac = MAC_BCAST;
            if ($urandom_range(0, 9) < 6) it.eth_src = it.arp_smac;
        end
        return it;
    endfunction

    task automatic push_item(input t_arp_item it);
        arp_backlog.push_back(it);
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (arp_backlog.size() != 0 || beats_out != beats_queued) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_own_ip(input t_ip value);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_OWN_IP, value, rd);
        own_ip_q = value;
        apb_xfer(1'b1, ADDR_SPARE, ~value, rd);
        apb_xfer(1'b0, ADDR_OWN_IP, '0, rd);
        if (rd !== value) begin
            $display("%0t: own_ip readback expected %0h got %0h", $time, value, rd);
            errors++;
        end
    endtask

    task automatic check_field(input string name, input t_cnt want_v, input t_cnt got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    // driver: hold the beat until accepted, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdict_q.push_back(inspect_arp(on_wire));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (arp_backlog.size() != 0) begin
                    on_wire = arp_backlog.pop_front();
                    i_func        <= on_wire.func;
                    i_arp_op      <= on_wire.op;
                    i_eth_src_mac <= on_wire.eth_src;
                    i_eth_dst_mac <= on_wire.eth_dst;
                    i_arp_src_mac <= on_wire.arp_smac;
                    i_arp_dst_mac <= on_wire.arp_dmac;
                    i_arp_src_ip  <= on_wire.sip;
                    i_arp_dst_ip  <= on_wire.dip;
                    i_in_valid    <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        gap_left <= $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("inconsistency_notice", 32'(want.inconsistency_notice),
                                32'(o_inconsistency_notice));
                    check_field("sender_mac_mismatch", 32'(want.sender_mac_mismatch),
                                32'(o_sender_mac_mismatch));
                    check_field("request_not_broadcast", 32'(want.request_not_broadcast),
                                32'(o_request_not_broadcast));
                    check_field("binding_missing_error", 32'(want.binding_missing_error),
                                32'(o_binding_missing_error));
                    check_field("reply_to_broadcast", 32'(want.reply_to_broadcast),
                                32'(o_reply_to_broadcast));
                    check_field("bind_to_broadcast_error", 32'(want.bind_to_broadcast_error),
                                32'(o_bind_to_broadcast_error));
                    check_field("pair_table_full", 32'(want.pair_table_full),
                                32'(o_pair_table_full));
                    check_field("pair_count", want.pair_count, o_pair_count);
                    check_field("binding_dropped", 32'(want.binding_dropped),
                                32'(o_binding_dropped));
                end
            end
            if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall_left  <= $urandom_range(0, 11);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_mac mac_a;
        t_mac mac_b;
        t_ip  ip_a;
        t_ip  ip_b;
        t_ip  ip_c;
        t_ip  ip_d;
        t_ip  own_a;
        int   k;
        mac_a = 48'h0200_1122_3344;
        mac_b = 48'h0200_5566_7788;
        ip_a  = 32'h0A00_0005;
        ip_b  = 32'h0A00_0063;
        ip_c  = 32'hAC10_0102;
        ip_d  = 32'hAC10_0203;
        own_a = 32'hC0A8_0001;
        cycle_cnt    = 0;
        beats_queued = 0;
        beats_out    = 0;
        errors       = 0;
        own_ip_q     = '0;
        pair_used    = 0;
        bind_used    = 0;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_out_ready   <= 1'b0;
        i_func        <= FUNC_INSPECT;
        i_arp_op      <= OP_OTHER;
        i_eth_src_mac <= '0;
        i_eth_dst_mac <= '0;
        i_arp_src_mac <= '0;
        i_arp_dst_mac <= '0;
        i_arp_src_ip  <= '0;
        i_arp_dst_ip  <= '0;
        hold_kick     <= 1'b0;
        calm          <= 1'b0;
        for (k = 0; k < POOL; k++) begin
            ip_pool[k]  = $urandom;
            mac_pool[k] = rand_mac();
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_own_ip(own_a);
        // loads ignore the opcode; duplicates append again
        push_item(mk(FUNC_LOAD, OP_RESERVED, rand_mac(), rand_mac(), mac_a, rand_mac(),
                     ip_a, $urandom));
        push_item(mk(FUNC_LOAD, OP_REQUEST, rand_mac(), rand_mac(), mac_a, rand_mac(),
                     ip_a, $urandom));
        push_item(mk(FUNC_LOAD, OP_OTHER, '0, '0, MAC_BCAST, '0, '1, '0));
        push_item(mk(FUNC_INSPECT, OP_REPLY, mac_a, '0, mac_a, '0, ip_a, ip_b));
        push_item(mk(FUNC_INSPECT, OP_REPLY, mac_b, MAC_BCAST, rand_mac(), MAC_BCAST,
                     ip_c, ip_a));
        push_item(mk(FUNC_INSPECT, OP_REPLY, MAC_BCAST, rand_mac(), MAC_BCAST, rand_mac(),
                     '1, $urandom));
        push_item(mk(FUNC_INSPECT, OP_OTHER, rand_mac(), rand_mac(), rand_mac(), rand_mac(),
                     $urandom, $urandom));
        push_item(mk(FUNC_INSPECT, OP_RESERVED, rand_mac(), rand_mac(), rand_mac(),
                     rand_mac(), $urandom, $urandom));
        // own sender: no second lookup
        repeat (2) push_item(mk(FUNC_INSPECT, OP_REQUEST, mac_a, MAC_BCAST, mac_a, '0,
                                own_a, ip_b));
        // own pair absent: notice once the count passes the margin
        repeat (5) push_item(mk(FUNC_INSPECT, OP_REQUEST, mac_b, MAC_BCAST, mac_b, '0,
                                ip_c, ip_d));
        // own pair ahead: difference wraps
        repeat (2) push_item(mk(FUNC_INSPECT, OP_REQUEST, mac_b, MAC_BCAST, mac_b, '0,
                                ip_c, ip_b));
        push_item(mk(FUNC_INSPECT, OP_REQUEST, '0, '0, MAC_BCAST, MAC_BCAST, '0, '0));
        push_item(mk(FUNC_INSPECT, OP_REQUEST, MAC_BCAST, MAC_BCAST, '0, '0, '1, '1));
        push_item(mk(FUNC_INSPECT, OP_REQUEST, rand_mac(), rand_mac(), rand_mac(),
                     rand_mac(), $urandom, $urandom));
        push_item(mk(FUNC_INSPECT, OP_REPLY, rand_mac(), rand_mac(), rand_mac(),
                     rand_mac(), $urandom, $urandom));
        wait_drained();

        set_own_ip('1);
        repeat (130) push_item(random_item());
        @(posedge i_clk);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        wait_drained();

        set_own_ip(ip_pool[0]);
        repeat (50) begin
            k = $urandom_range(0, POOL - 1);
            push_item(mk(FUNC_LOAD, 2'($urandom_range(0, 3)), rand_mac(), rand_mac(),
                         mac_pool[k], rand_mac(), ip_pool[k], $urandom));
        end
        // fill the pair table with fresh pairs
        repeat (110) begin
            mac_b = rand_mac();
            push_item(mk(FUNC_INSPECT, OP_REQUEST, mac_b, MAC_BCAST, mac_b, rand_mac(),
                         $urandom, $urandom));
        end
        repeat (80) push_item(random_item());
        wait_drained();

        set_own_ip('0);
        calm <= 1'b1;
        repeat (60) push_item(random_item());
        wait_drained();
        repeat (300) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/arpi_pkg.sv
hw/rtl/arpi_tbl.sv
hw/rtl/arpi_alu.sv
hw/rtl/arp_packet_inspector_core.sv
sim/tb.sv
